// ----- rtl/mtms_pkg.sv -----
// ----------------------------------------------------------------------------
// MIDI track marker scanner - shared types and constants
// Phase codes, item and result structures, channel message width lookup.
// ----------------------------------------------------------------------------
package mtms_pkg;

  localparam int unsigned VlqMaxBytes = 4;
  localparam int unsigned VlqCntW     = 3;
  localparam int unsigned VlqValW     = 28;
  localparam int unsigned TickW       = 32;

  localparam logic [7:0] MarkerTypeRst = 8'h06;
  localparam logic [7:0] StMeta        = 8'hFF;
  localparam logic [7:0] StSysex       = 8'hF0;
  localparam logic [7:0] StSysexEsc    = 8'hF7;

  localparam logic [3:0] NibNoteOff  = 4'h8;
  localparam logic [3:0] NibNoteOn   = 4'h9;
  localparam logic [3:0] NibPolyAt   = 4'hA;
  localparam logic [3:0] NibCtrl     = 4'hB;
  localparam logic [3:0] NibProg     = 4'hC;
  localparam logic [3:0] NibChanAt   = 4'hD;
  localparam logic [3:0] NibPitch    = 4'hE;

  typedef enum logic [3:0] {
    PhDelta  = 4'd0,
    PhStatus = 4'd1,
    PhChan   = 4'd2,
    PhMtype  = 4'd3,
    PhMlen   = 4'd4,
    PhMbody  = 4'd5,
    PhSlen   = 4'd6,
    PhSbody  = 4'd7,
    PhStop   = 4'd8
  } phase_e;

  typedef enum logic [1:0] {
    KindText    = 2'd0,
    KindEmpty   = 2'd1,
    KindAbandon = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       track_start;
    logic       track_end;
  } in_item_t;

  typedef struct packed {
    logic              valid;
    kind_e             kind;
    logic [TickW-1:0]  tick;
    logic [7:0]        text_byte;
    logic              first;
    logic              last;
  } result_t;

  // Number of data bytes that follow a channel status; zero if not a channel status
  function automatic logic [1:0] chan_width(input logic [7:0] st);
    logic [1:0] w;
    begin
      case (st[7:4]) inside
        NibNoteOff, NibNoteOn, NibPolyAt, NibCtrl, NibPitch: w = 2'd2;
        NibProg, NibChanAt:                                   w = 2'd1;
        default:                                              w = 2'd0;
      endcase
      return w;
    end
  endfunction

endpackage

// ----- rtl/mtms_in_reg.sv -----
// ----------------------------------------------------------------------------
// MIDI track marker scanner - input register
// Holds one accepted track byte until the decoder takes it.
// ----------------------------------------------------------------------------
module mtms_in_reg
  import mtms_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_item_t   item_i,
  input  logic       take_i,
  output logic       valid_o,
  output in_item_t   item_o
);

  logic     valid_q;
  in_item_t item_q;

  assign in_ready_o = !valid_q || take_i;
  assign valid_o    = valid_q;
  assign item_o     = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= item_i;
    end
  end

endmodule

// ----- rtl/mtms_decode.sv -----
// ----------------------------------------------------------------------------
// MIDI track marker scanner - event decoder
// Track state, delta time and length decoding, marker result generation.
// ----------------------------------------------------------------------------
module mtms_decode
  import mtms_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [7:0] cfg_data_i,
  input  logic       take_i,
  input  in_item_t   item_i,
  output result_t    res_o
);

  logic [7:0]         mtype_q;
  phase_e             phase_q, phase_d;
  logic [TickW-1:0]   tick_q, tick_d;
  logic [7:0]         rs_q, rs_d;
  logic [VlqValW-1:0] vval_q, vval_d;
  logic [VlqCntW-1:0] vcnt_q, vcnt_d;
  logic [VlqValW-1:0] left_q, left_d;
  logic               cap_q, cap_d;
  logic               seen_q, seen_d;

  // Quantity feed for the current byte
  logic [VlqValW-1:0] vlq_acc;
  logic [VlqCntW-1:0] vlq_cnt;
  logic               vlq_done;
  logic               vlq_over;

  always_comb begin
    logic [7:0]         b;
    logic [1:0]         cw;
    logic [1:0]         rcw;
    phase_e             ph;
    begin
      b        = item_i.data_byte;
      vlq_acc  = 'x;
      vlq_cnt  = 'x;
      vlq_done = 1'b0;
      vlq_over = 1'b0;

      // track start clears state before the byte is decoded
      if (item_i.track_start) begin
        phase_d = PhDelta;
        tick_d  = '0;
        rs_d    = '0;
        vval_d  = '0;
        vcnt_d  = '0;
        left_d  = '0;
        cap_d   = 1'b0;
        seen_d  = 1'b0;
      end else begin
        phase_d = phase_q;
        tick_d  = tick_q;
        rs_d    = rs_q;
        vval_d  = vval_q;
        vcnt_d  = vcnt_q;
        left_d  = left_q;
        cap_d   = cap_q;
        seen_d  = seen_q;
      end

      vlq_acc  = {vval_d[VlqValW-8:0], b[6:0]};
      vlq_cnt  = vcnt_d + VlqCntW'(1);
      vlq_done = !b[7];
      vlq_over = b[7] && (vlq_cnt >= VlqCntW'(VlqMaxBytes));

      cw  = chan_width(b);
      rcw = chan_width(rs_d);
      ph  = phase_d;

      res_o           = '0;
      res_o.kind      = KindText;

      if (ph != PhStop) begin
        unique case (ph) inside
          PhDelta: begin
            if (vlq_done) begin
              tick_d  = tick_d + TickW'(vlq_acc);
              vval_d  = '0;
              vcnt_d  = '0;
              phase_d = PhStatus;
            end else if (vlq_over) begin
              vval_d  = '0;
              vcnt_d  = '0;
              phase_d = PhStop;
              cap_d   = 1'b0;
              left_d  = '0;
            end else begin
              vval_d = vlq_acc;
              vcnt_d = vlq_cnt;
            end
          end
          PhStatus: begin
            if (b[7]) begin
              rs_d = b;
              if (b == StMeta) begin
                rs_d    = '0;
                phase_d = PhMtype;
              end else if (b == StSysex || b == StSysexEsc) begin
                rs_d    = '0;
                phase_d = PhSlen;
              end else if (cw == 2'd0) begin
                phase_d = PhStop;
                cap_d   = 1'b0;
                left_d  = '0;
              end else begin
                left_d  = VlqValW'(cw);
                phase_d = PhChan;
              end
            end else if (rs_d[7] && rcw != 2'd0) begin
              // running status: this byte is the first data byte
              left_d  = VlqValW'(rcw - 2'd1);
              phase_d = (rcw != 2'd1) ? PhChan : PhDelta;
            end else begin
              phase_d = PhStop;
              cap_d   = 1'b0;
              left_d  = '0;
            end
          end
          PhChan: begin
            if (left_d != '0) begin
              left_d = left_d - VlqValW'(1);
            end
            if (left_d == '0) begin
              phase_d = PhDelta;
            end
          end
          PhMtype: begin
            cap_d   = (b == mtype_q);
            seen_d  = 1'b0;
            phase_d = PhMlen;
          end
          PhMlen, PhSlen: begin
            if (vlq_done) begin
              vval_d = '0;
              vcnt_d = '0;
              left_d = vlq_acc;
              if (vlq_acc == '0) begin
                if (ph == PhMlen && cap_d) begin
                  res_o.valid = 1'b1;
                  res_o.kind  = KindEmpty;
                  res_o.tick  = tick_d;
                  res_o.last  = 1'b1;
                  cap_d       = 1'b0;
                end
                phase_d = PhDelta;
              end else begin
                phase_d = (ph == PhMlen) ? PhMbody : PhSbody;
              end
            end else if (vlq_over) begin
              vval_d  = '0;
              vcnt_d  = '0;
              phase_d = PhStop;
              cap_d   = 1'b0;
              left_d  = '0;
            end else begin
              vval_d = vlq_acc;
              vcnt_d = vlq_cnt;
            end
          end
          PhMbody, PhSbody: begin
            if (left_d != '0) begin
              left_d = left_d - VlqValW'(1);
            end
            if (ph == PhMbody && cap_d) begin
              res_o.valid     = 1'b1;
              res_o.kind      = KindText;
              res_o.tick      = tick_d;
              res_o.text_byte = b;
              res_o.first     = !seen_d;
              res_o.last      = (left_d == '0);
              seen_d          = 1'b1;
              if (left_d == '0) begin
                cap_d = 1'b0;
              end
            end
            if (left_d == '0) begin
              phase_d = PhDelta;
            end
          end
          default: begin
            phase_d = PhStop;
            cap_d   = 1'b0;
            left_d  = '0;
          end
        endcase

        // marker still open at the end of the track: abandon it
        if (item_i.track_end) begin
          if (cap_d) begin
            res_o           = '0;
            res_o.valid     = 1'b1;
            res_o.kind      = KindAbandon;
            res_o.tick      = tick_d;
          end
          phase_d = PhStop;
          cap_d   = 1'b0;
          left_d  = '0;
        end
      end

      res_o.valid = res_o.valid && take_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mtype_q <= MarkerTypeRst;
    end else if (cfg_we_i) begin
      mtype_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhDelta;
      tick_q  <= '0;
      rs_q    <= '0;
      vval_q  <= '0;
      vcnt_q  <= '0;
      left_q  <= '0;
      cap_q   <= 1'b0;
      seen_q  <= 1'b0;
    end else if (take_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      rs_q    <= rs_d;
      vval_q  <= vval_d;
      vcnt_q  <= vcnt_d;
      left_q  <= left_d;
      cap_q   <= cap_d;
      seen_q  <= seen_d;
    end
  end

endmodule

// ----- rtl/mtms_out_reg.sv -----
// ----------------------------------------------------------------------------
// MIDI track marker scanner - result register
// Holds one marker result until the receiver takes it.
// ----------------------------------------------------------------------------
module mtms_out_reg
  import mtms_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     load_i,
  input  result_t  res_i,
  output logic     free_o,
  input  logic     out_ready_i,
  output result_t  res_o
);

  logic    valid_q;
  result_t res_q;

  assign free_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= res_i.valid;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_i.valid) begin
      res_q <= res_i;
    end
  end

  always_comb begin
    res_o       = res_q;
    res_o.valid = valid_q;
  end

endmodule

// ----- rtl/midi_track_marker_scanner_core.sv -----
// ----------------------------------------------------------------------------
// MIDI track marker scanner
// Decodes a MIDI track body byte by byte and reports marker meta text.
// ----------------------------------------------------------------------------
// Input channel: one track byte per request, with track start and end flags.
// Output channel: zero or one marker result per byte: text byte, empty marker
// or marker abandoned at track end, with the event tick and first/last flags.
// Config channel: writes the meta type reported as marker text (reset 0x06);
// always ready, write only while the block is idle.
// Data path: an accepted byte is held in the input register and decoded from
// there; its outcome is loaded into the result register and waits until taken.
// Throughput: one byte per cycle while the receiver keeps ready high; the
// per-byte state update sits between the input and result registers.
// Reset clears the track state; bytes before a track start are decoded as a
// track from tick 0. When the receiver stalls, the result is held, the input
// register fills and then input ready drops until the result is taken.
// ----------------------------------------------------------------------------
module midi_track_marker_scanner_core
  import mtms_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [7:0]       cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [7:0]       data_byte_i,
  input  logic             track_start_i,
  input  logic             track_end_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [1:0]       kind_o,
  output logic [TickW-1:0] tick_o,
  output logic [7:0]       text_byte_o,
  output logic             first_o,
  output logic             last_o
);

  in_item_t in_item;
  in_item_t s1_item;
  logic     s1_valid;
  logic     out_free;
  logic     take;
  result_t  res;
  result_t  out_res;

  assign cfg_ready_o = 1'b1;

  assign in_item.data_byte   = data_byte_i;
  assign in_item.track_start = track_start_i;
  assign in_item.track_end   = track_end_i;

  // advance a held byte only when the result slot can take its outcome
  assign take = s1_valid && out_free;

  mtms_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .item_i     (in_item),
    .take_i     (take),
    .valid_o    (s1_valid),
    .item_o     (s1_item)
  );

  mtms_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .take_i     (take),
    .item_i     (s1_item),
    .res_o      (res)
  );

  mtms_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (take),
    .res_i       (res),
    .free_o      (out_free),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign out_valid_o = out_res.valid;
  assign kind_o      = out_res.kind;
  assign tick_o      = out_res.tick;
  assign text_byte_o = out_res.text_byte;
  assign first_o     = out_res.first;
  assign last_o      = out_res.last;

endmodule
